>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("%m: invariant violated");
// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: implication violated");
`else
`define ASSERT_ALWAYS(label, clk, rst, cond)
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`endif

`endif

>>> design/crd_pkg.sv
// ----------------------------------------------------------------------------
// crd_pkg
// Widths, scaling constants and shared types for the current rise detector.
// ----------------------------------------------------------------------------
package crd_pkg;

  localparam int SAMPLES_PER_POINT = 16;
  localparam int HISTORY_DEPTH     = 16;

  // Field widths
  localparam int ADC_W   = 11;
  localparam int POINT_W = 14;
  localparam int MAG_W   = 13;
  localparam int CHG_W   = 14;
  localparam int PROD_W  = 27;

  // Group accumulator: one spare bit so the magnitude never overflows
  localparam int SUM_W = ADC_W + $clog2(SAMPLES_PER_POINT) + 1;
  localparam int CNT_W = $clog2(SAMPLES_PER_POINT);

  // Scaling: point = sum * SCALE_MUL / SCALE_DIV, toward zero
  localparam int SCALE_MUL = 1000 / SAMPLES_PER_POINT;
  localparam int SCALE_DIV = 660000 / 4882;
  localparam int MUL_W     = $clog2(SCALE_MUL + 1);
  localparam int X_W       = SUM_W + MUL_W;

  // Divide by SCALE_DIV as multiply by rounded-up reciprocal.
  // Error term is below SCALE_DIV <= 2^DIV_W, so the shift below is exact
  // for every X_W-bit dividend.
  localparam int    DIV_W       = $clog2(SCALE_DIV);
  localparam int    RECIP_SHIFT = X_W + DIV_W;
  localparam longint RECIP_MUL  =
    ((64'd1 << RECIP_SHIFT) + SCALE_DIV - 1) / SCALE_DIV;
  localparam int    RECIP_W     = $clog2(RECIP_MUL + 1);
  localparam int    Y_W         = X_W + RECIP_W;

  // History rings
  localparam int HIST_W = $clog2(HISTORY_DEPTH);

  // Queue between accumulator and point pipeline
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef logic signed [SUM_W-1:0] sum_t;

  typedef struct packed {
    logic valid;
    sum_t sum;
  } sum_push_t;

  typedef struct packed {
    logic empty;
    logic full;
  } queue_status_t;

endpackage

>>> design/crd_front.sv
// ----------------------------------------------------------------------------
// crd_front
// Sample accumulator: sums each group and pushes the finished sum.
// ----------------------------------------------------------------------------
module crd_front import crd_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    sample_valid,
  output logic                    sample_ready,
  input  logic signed [ADC_W-1:0] adc_sample,
  input  queue_status_t           qstat,
  output sum_push_t               push
);

  sum_t             group_sum;
  sum_t             sum_next;
  logic [CNT_W-1:0] sample_count;
  logic             accept;
  logic             last;

  assign sample_ready = !qstat.full;
  assign accept       = sample_valid && sample_ready;
  assign last         = (sample_count == CNT_W'(SAMPLES_PER_POINT - 1));
  assign sum_next     = group_sum + SUM_W'(adc_sample);

  assign push.valid = accept && last;
  assign push.sum   = sum_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      group_sum    <= '0;
      sample_count <= '0;
    end else if (accept) begin
      if (last) begin
        group_sum    <= '0;
        sample_count <= '0;
      end else begin
        group_sum    <= sum_next;
        sample_count <= sample_count + 1'b1;
      end
    end
  end

endmodule

>>> design/crd_queue.sv
// ----------------------------------------------------------------------------
// crd_queue
// Short FIFO of group sums between the accumulator and the point pipeline.
// ----------------------------------------------------------------------------
module crd_queue import crd_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  sum_push_t     push,
  input  logic          pop,
  output sum_t          head,
  output queue_status_t qstat
);

  sum_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  function automatic logic [QPTR_W-1:0] wrap_inc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign head        = mem[rd_ptr];
  assign qstat.empty = (count == '0);
  assign qstat.full  = (count == QCNT_W'(QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem[wr_ptr] <= push.sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr <= wrap_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= wrap_inc(rd_ptr);
      end
      if (push.valid && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push.valid) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> design/crd_back.sv
// ----------------------------------------------------------------------------
// crd_back
// Point pipeline: scale, magnitude rise, rise change, product, output reg.
// ----------------------------------------------------------------------------
module crd_back import crd_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  sum_t                      head,
  input  queue_status_t             qstat,
  output logic                      pop,
  output logic                      result_valid,
  input  logic                      result_ready,
  output logic signed [POINT_W-1:0] scaled_current,
  output logic        [MAG_W-1:0]   magnitude_rise,
  output logic signed [CHG_W-1:0]   rise_change,
  output logic signed [PROD_W-1:0]  rise_product
);

  logic adv;

  // stage 1: |sum| * SCALE_MUL
  logic             s1_valid;
  logic             s1_neg;
  logic [X_W-1:0]   s1_x;
  logic [SUM_W-1:0] abs_sum;

  // stage 2: reciprocal product
  logic           s2_valid;
  logic           s2_neg;
  logic [Y_W-1:0] s2_y;

  // stage 3: point and magnitude rise
  logic                      s3_valid;
  logic signed [POINT_W-1:0] s3_point;
  logic        [MAG_W-1:0]   s3_rise;
  logic        [MAG_W-1:0]   q;
  logic        [MAG_W:0]     mag_diff;
  logic        [MAG_W-1:0]   rise_val;

  // stage 4: rise change
  logic                      s4_valid;
  logic signed [POINT_W-1:0] s4_point;
  logic        [MAG_W-1:0]   s4_rise;
  logic signed [CHG_W-1:0]   s4_change;
  logic signed [CHG_W-1:0]   change_val;
  logic signed [CHG_W+MAG_W:0] prod_full;

  // history rings, each with its own write pointer
  logic [MAG_W-1:0]  mag_hist  [HISTORY_DEPTH];
  logic [MAG_W-1:0]  rise_hist [HISTORY_DEPTH];
  logic [HIST_W-1:0] mag_pos;
  logic [HIST_W-1:0] rise_pos;
  logic [HIST_W-1:0] mag_next;
  logic [HIST_W-1:0] rise_next;

  function automatic logic [HIST_W-1:0] ring_inc(input logic [HIST_W-1:0] p);
    return (p == HIST_W'(HISTORY_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign adv = !result_valid || result_ready;
  assign pop = adv && !qstat.empty;

  assign abs_sum = head[SUM_W-1] ? SUM_W'(-head) : SUM_W'(head);

  assign mag_next  = ring_inc(mag_pos);
  assign rise_next = ring_inc(rise_pos);

  assign q        = s2_y[RECIP_SHIFT +: MAG_W];
  assign mag_diff = {1'b0, q} - {1'b0, mag_hist[mag_next]};
  assign rise_val = mag_diff[MAG_W] ? '0 : mag_diff[MAG_W-1:0];

  assign change_val = $signed({1'b0, s3_rise}) - $signed({1'b0, rise_hist[rise_next]});

  assign prod_full = $signed({1'b0, s4_rise}) * s4_change;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      s3_valid     <= 1'b0;
      s4_valid     <= 1'b0;
      result_valid <= 1'b0;
      mag_pos      <= '0;
      rise_pos     <= '0;
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        mag_hist[i]  <= '0;
        rise_hist[i] <= '0;
      end
    end else if (adv) begin
      s1_valid     <= pop;
      s2_valid     <= s1_valid;
      s3_valid     <= s2_valid;
      s4_valid     <= s3_valid;
      result_valid <= s4_valid;
      if (s2_valid) begin
        mag_hist[mag_pos] <= q;
        mag_pos           <= mag_next;
      end
      if (s3_valid) begin
        rise_hist[rise_pos] <= s3_rise;
        rise_pos            <= rise_next;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_neg <= head[SUM_W-1];
      s1_x   <= X_W'(abs_sum) * X_W'(SCALE_MUL);

      s2_neg <= s1_neg;
      s2_y   <= Y_W'(s1_x) * Y_W'(RECIP_MUL);

      s3_point <= s2_neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
      s3_rise  <= rise_val;

      s4_point  <= s3_point;
      s4_rise   <= s3_rise;
      s4_change <= change_val;

      scaled_current <= s4_point;
      magnitude_rise <= s4_rise;
      rise_change    <= s4_change;
      rise_product   <= prod_full[PROD_W-1:0];
    end
  end

endmodule

>>> design/current_rise_detector_chain_core.sv
// ----------------------------------------------------------------------------
// current_rise_detector_chain_core
// Group-averaged current points with rise detection against history rings.
// ----------------------------------------------------------------------------
// Usage:
//   Sample channel (sample_valid/sample_ready, adc_sample): one signed 11-bit
//   converter sample per item; an item can be taken every clock cycle while the queue is not full.
//   Result channel (result_valid/result_ready): one result per group of
//   SAMPLES_PER_POINT samples, carrying scaled_current, magnitude_rise,
//   rise_change and rise_product. Other samples produce nothing.
//   Result path: after the last sample of its group is taken, the sum passes
//   the queue write, scale multiply, reciprocal multiply, rise stage and
//   change stage into the output register.
//   Throughput: 1 sample per cycle while sample_ready is high, set by the
//   accumulator adder; the point pipeline only sees one item per group.
//   Stall: a pending result with result_ready low freezes the point pipeline;
//   group sums collect in a 4-entry queue; sample_ready drops only when full.
//   Reset (rst, synchronous): clears accumulator, queue, pipeline valids,
//   ring pointers and both history rings, so early points compare against 0.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module current_rise_detector_chain_core import crd_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      sample_valid,
  output logic                      sample_ready,
  input  logic signed [ADC_W-1:0]   adc_sample,
  output logic                      result_valid,
  input  logic                      result_ready,
  output logic signed [POINT_W-1:0] scaled_current,
  output logic        [MAG_W-1:0]   magnitude_rise,
  output logic signed [CHG_W-1:0]   rise_change,
  output logic signed [PROD_W-1:0]  rise_product
);

  sum_push_t     push;
  queue_status_t qstat;
  sum_t          head;
  logic          pop;

  // front: accumulate samples, push one sum per group
  crd_front u_front (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .adc_sample   (adc_sample),
    .qstat        (qstat),
    .push         (push)
  );

  // decoupling queue
  crd_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .qstat (qstat)
  );

  // back: scale, rise, change, product
  crd_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head           (head),
    .qstat          (qstat),
    .pop            (pop),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .scaled_current (scaled_current),
    .magnitude_rise (magnitude_rise),
    .rise_change    (rise_change),
    .rise_product   (rise_product)
  );

  // magnitude of the output point, for the rise bound check
  logic [POINT_W-1:0] point_abs;
  logic [POINT_W-1:0] rise_wide;
  logic               both_nonzero;
  logic               sign_match;
  assign point_abs = scaled_current[POINT_W-1] ? POINT_W'(-scaled_current)
                                               : POINT_W'(scaled_current);
  assign rise_wide    = POINT_W'(magnitude_rise);
  assign both_nonzero = (magnitude_rise != '0) && (rise_change != '0);
  assign sign_match   = (rise_product[PROD_W-1] == rise_change[CHG_W-1]);

  // the front never pushes into a full queue
  `ASSERT_IMPLY(a_no_overflow, clk, rst, push.valid, !qstat.full)
  // the back never pops an empty queue
  `ASSERT_IMPLY(a_no_underflow, clk, rst, pop, !qstat.empty)
  // a clamped rise never exceeds the current magnitude
  `ASSERT_IMPLY(a_rise_bound, clk, rst, result_valid, rise_wide <= point_abs)
  // product sign follows the change sign when both factors are nonzero
  `ASSERT_IMPLY(a_prod_sign, clk, rst, result_valid && both_nonzero, sign_match)

endmodule

>>> bench/current_rise_detector_chain_core_tb.sv
// ----------------------------------------------------------------------------
// current_rise_detector_chain_core_tb
// Streams converter samples into the rise detector, predicts each group's
// point, rise, change and product, and checks every result item in order.
// Covers extremes, step levels, random samples, idling and back-pressure.
// ----------------------------------------------------------------------------
module current_rise_detector_chain_core_tb import crd_pkg::*;;

  // Expected contents of one result item
  typedef struct {
    logic signed [POINT_W-1:0] current;
    logic        [MAG_W-1:0]   rise;
    logic signed [CHG_W-1:0]   change;
    logic signed [PROD_W-1:0]  product;
  } point_result_t;

  localparam int HOLD_CYCLES = 300;      // long receiver hold-off
  localparam int DRAIN_CYCLES = 20;      // settle time after the last expected point

  logic                      clk;
  logic                      rst;
  logic                      sample_valid;
  logic                      sample_ready;
  logic signed [ADC_W-1:0]   adc_sample;
  logic                      result_valid;
  logic                      result_ready;
  logic signed [POINT_W-1:0] scaled_current;
  logic        [MAG_W-1:0]   magnitude_rise;
  logic signed [CHG_W-1:0]   rise_change;
  logic signed [PROD_W-1:0]  rise_product;

  current_rise_detector_chain_core dut (
    .clk            (clk),
    .rst            (rst),
    .sample_valid   (sample_valid),
    .sample_ready   (sample_ready),
    .adc_sample     (adc_sample),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .scaled_current (scaled_current),
    .magnitude_rise (magnitude_rise),
    .rise_change    (rise_change),
    .rise_product   (rise_product)
  );

  // Clock: period 2
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predictor state, mirrors the block's accumulator and rings
  int                 group_acc;
  int                 group_fill;
  logic [HIST_W-1:0]  ring_wr;
  logic [MAG_W-1:0]   mag_ring [HISTORY_DEPTH];
  logic [MAG_W-1:0]   rise_ring [HISTORY_DEPTH];
  point_result_t      pending_points [$];

  int error_count;
  int samples_sent;
  int points_checked;

  // Idle chances in percent, changed per test
  int send_idle_pct;
  int recv_idle_pct;

  // Receiver hold-off
  event hold_off_start;
  logic holding = 1'b0;

  // --------------------------------------------------------------------------
  // Prediction: fold one accepted item into the group; a full group
  // produces one expected point.
  // --------------------------------------------------------------------------
  task automatic take_sample(input logic signed [ADC_W-1:0] s);
    int            point;
    int            mag;
    int            rise;
    int            change;
    logic [HIST_W-1:0] nxt;
    point_result_t exp_pt;
    begin
      group_acc  = group_acc + int'(s);
      group_fill = group_fill + 1;
      if (group_fill == SAMPLES_PER_POINT) begin
        // SV integer division truncates toward zero
        point      = (group_acc * SCALE_MUL) / SCALE_DIV;
        group_acc  = 0;
        group_fill = 0;
        mag = (point < 0) ? -point : point;
        nxt = ring_wr + 1'b1;    // wraps at HISTORY_DEPTH (power of two)
        // Compare against the entry written HISTORY_DEPTH-1 points back;
        // early on that entry still holds its reset zero.
        mag_ring[ring_wr] = mag[MAG_W-1:0];
        rise = mag - int'(mag_ring[nxt]);
        if (rise < 0) rise = 0;
        rise_ring[ring_wr] = rise[MAG_W-1:0];
        change = rise - int'(rise_ring[nxt]);
        ring_wr = nxt;
        exp_pt.current = point[POINT_W-1:0];
        exp_pt.rise    = rise[MAG_W-1:0];
        exp_pt.change  = change[CHG_W-1:0];
        exp_pt.product = PROD_W'(rise * change);
        pending_points.push_back(exp_pt);
      end
    end
  endtask

  task automatic report_mismatch(input string msg);
    begin
      error_count++;
      $display("MISMATCH @%0t: %s", $realtime, msg);
    end
  endtask

  // --------------------------------------------------------------------------
  // Sender: optional idle cycles, then hold the item until accepted.
  // Valid only changes at the falling edge, once per edge.
  // --------------------------------------------------------------------------
  task automatic send_sample(input logic signed [ADC_W-1:0] s);
    int gap;
    begin
      gap = 0;
      while (gap < 8 && $urandom_range(99) < send_idle_pct) gap++;
      repeat (gap) begin
        @(negedge clk);
        sample_valid <= 1'b0;
        adc_sample   <= ADC_W'($urandom);
      end
      @(negedge clk);
      sample_valid <= 1'b1;
      adc_sample   <= s;
      do @(posedge clk); while (!sample_ready);
      take_sample(s);
      samples_sent++;
    end
  endtask

  // One group at a constant level, optionally with small noise
  task automatic send_group(input int level, input bit noisy);
    int v;
    begin
      repeat (SAMPLES_PER_POINT) begin
        v = level;
        if (noisy) v = v + $urandom_range(64) - 32;
        if (v > 1023) v = 1023;
        if (v < -1024) v = -1024;
        send_sample(v[ADC_W-1:0]);
      end
    end
  endtask

  // Level choice weighted toward the rails so large rises and drops occur
  function automatic int pick_level();
    int r;
    begin
      r = $urandom_range(9);
      if (r < 3) pick_level = 1023;
      else if (r < 6) pick_level = -1024;
      else if (r < 7) pick_level = 0;
      else pick_level = $urandom_range(2047) - 1024;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Receiver: random ready at the falling edge; forced low while holding.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (holding) begin
      result_ready <= 1'b0;
    end else begin
      result_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Hold-off counter, runs in its own process
  always begin
    @(hold_off_start);
    holding = 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    holding = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Checker: every accepted result item against the oldest expectation.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    point_result_t want;
    if (!rst && result_valid && result_ready) begin
      if (pending_points.size() == 0) begin
        report_mismatch($sformatf("result item with nothing expected (current %0d)",
                                  scaled_current));
      end else begin
        want = pending_points.pop_front();
        if (scaled_current !== want.current)
          report_mismatch($sformatf("point %0d scaled_current got %0d want %0d",
                                    points_checked, scaled_current, want.current));
        if (magnitude_rise !== want.rise)
          report_mismatch($sformatf("point %0d magnitude_rise got %0d want %0d",
                                    points_checked, magnitude_rise, want.rise));
        if (rise_change !== want.change)
          report_mismatch($sformatf("point %0d rise_change got %0d want %0d",
                                    points_checked, rise_change, want.change));
        if (rise_product !== want.product)
          report_mismatch($sformatf("point %0d rise_product got %0d want %0d",
                                    points_checked, rise_product, want.product));
      end
      points_checked++;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Input rails: first points compare against cleared rings, then a swing
  // from full positive to full negative; each still rises by its full magnitude.
  task automatic test_extremes();
    begin
      send_group(1023, 1'b0);
      send_group(-1024, 1'b0);
    end
  endtask

  // Step levels with no idling on either side; drives rises to full scale
  // and, a ring length later, changes to full negative.
  task automatic test_step_levels();
    begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
      repeat (40) send_group(pick_level(), $urandom_range(3) == 0);
      send_idle_pct = 27;
      recv_idle_pct = 27;
    end
  endtask

  // Unstructured samples across the full range, random idling
  task automatic test_random_samples();
    begin
      repeat (40 * SAMPLES_PER_POINT) send_sample(ADC_W'($urandom));
    end
  endtask

  // Receiver holds off while the sender keeps offering items back to back,
  // so the sum queue fills and sample_ready drops.
  task automatic test_backpressure();
    begin
      send_idle_pct = 0;
      -> hold_off_start;
      repeat (10) send_group(pick_level(), 1'b1);
      send_idle_pct = 27;
    end
  endtask

  // Mostly well-formed level groups, some broken by random samples
  task automatic test_mixed();
    begin
      repeat (30) begin
        if ($urandom_range(3) == 0) begin
          repeat (SAMPLES_PER_POINT) send_sample(ADC_W'($urandom));
        end else begin
          send_group(pick_level(), $urandom_range(1));
        end
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst            = 1'b1;
    sample_valid   = 1'b0;
    adc_sample     = '0;
    send_idle_pct  = 27;
    recv_idle_pct  = 27;
    error_count    = 0;
    samples_sent   = 0;
    points_checked = 0;
    group_acc      = 0;
    group_fill     = 0;
    ring_wr        = '0;
    for (int k = 0; k < HISTORY_DEPTH; k++) begin
      mag_ring[k]  = '0;
      rise_ring[k] = '0;
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_extremes();
    test_step_levels();
    test_random_samples();
    test_backpressure();
    test_mixed();

    @(negedge clk);
    sample_valid <= 1'b0;

    // Drain; the separate timeout bounds this wait
    while (pending_points.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d samples and %0d result items: rails, step levels,",
             samples_sent, points_checked);
    $display("random samples, idling on both sides and a long receiver hold-off.");
    if (error_count == 0) begin
      $display("current_rise_detector_chain_core_tb: clean");
    end else begin
      $display("current_rise_detector_chain_core_tb: errors");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #400000;
    $display("Timeout with %0d result items still expected", pending_points.size());
    $display("current_rise_detector_chain_core_tb: errors");
    $finish;
  end

endmodule
